[rtl/gait_keypoint_window_detector_defines.svh]
// Assertion macros shared by the gait key-point window detector.
`ifndef GAIT_KEYPOINT_WINDOW_DETECTOR_DEFINES_SVH
`define GAIT_KEYPOINT_WINDOW_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GKWD_ASSERT_IMPLY(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define GKWD_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gkwd_pkg.sv]
package gkwd_pkg;

    localparam int WINDOW_DEF      = 15;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int LIM_BITS   = 16;
    localparam int CODE_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ACC_SQ_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIN_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_PEAK_LIMIT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] ACC_SQ_LIMIT_RST = 32'd4194304;

    localparam logic [CODE_W-1:0] CODE_FILL       = 3'd0;
    localparam logic [CODE_W-1:0] CODE_NORMAL     = 3'd1;
    localparam logic [CODE_W-1:0] CODE_ANGLE_MIN  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_GYRO_PEAK  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_ZERO_CROSS = 3'd4;
    localparam logic [CODE_W-1:0] CODE_LOW_ACC    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SHIFT,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

[rtl/gkwd_mag.sv]
module gkwd_mag #(
    parameter int SAMPLE_BITS = gkwd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic signed [SAMPLE_BITS-1:0]     i_acc_x,
    input  logic signed [SAMPLE_BITS-1:0]     i_acc_y,
    input  logic signed [SAMPLE_BITS-1:0]     i_acc_z,
    input  logic [gkwd_pkg::CFG_DATA_W-1:0]   i_limit,
    output logic                              o_low
);

    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int SUM_W = (SQ_W + 2 > gkwd_pkg::CFG_DATA_W + 1) ? SQ_W + 2
                                                                 : gkwd_pkg::CFG_DATA_W + 1;

    logic [SAMPLE_BITS-1:0] r_abs_x, r_abs_y, r_abs_z;
    logic [SQ_W-1:0]        r_sq_x, r_sq_y, r_sq_z;
    logic [SUM_W-1:0]       sum;

    // Magnitude fits in SAMPLE_BITS unsigned bits, the most negative value included.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_abs_x <= i_acc_x[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_acc_x) : SAMPLE_BITS'(i_acc_x);
            r_abs_y <= i_acc_y[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_acc_y) : SAMPLE_BITS'(i_acc_y);
            r_abs_z <= i_acc_z[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_acc_z) : SAMPLE_BITS'(i_acc_z);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_x <= SQ_W'(r_abs_x) * SQ_W'(r_abs_x);
        r_sq_y <= SQ_W'(r_abs_y) * SQ_W'(r_abs_y);
        r_sq_z <= SQ_W'(r_abs_z) * SQ_W'(r_abs_z);
    end

    assign sum   = SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);
    assign o_low = (sum <= SUM_W'(i_limit));

endmodule

[rtl/gkwd_cell.sv]
module gkwd_cell #(
    parameter int SAMPLE_BITS = gkwd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic signed [SAMPLE_BITS-1:0] i_gyro,
    input  logic signed [SAMPLE_BITS-1:0] i_angle,
    input  logic                          i_low,
    input  logic signed [SAMPLE_BITS-1:0] i_min,
    input  logic signed [SAMPLE_BITS-1:0] i_max,
    output logic signed [SAMPLE_BITS-1:0] o_gyro,
    output logic signed [SAMPLE_BITS-1:0] o_angle,
    output logic                          o_low,
    output logic signed [SAMPLE_BITS-1:0] o_min,
    output logic signed [SAMPLE_BITS-1:0] o_max
);

    logic signed [SAMPLE_BITS-1:0] r_gyro, r_angle, r_min, r_max;
    logic                          r_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low <= 1'b0;
        end else if (i_shift) begin
            r_low <= i_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_gyro  <= i_gyro;
            r_angle <= i_angle;
        end
    end

    // Fold this entry into the running extremes coming from the neighbor.
    always_ff @(posedge i_clk) begin
        r_min <= (r_angle < i_min) ? r_angle : i_min;
        r_max <= (r_gyro > i_max) ? r_gyro : i_max;
    end

    assign o_gyro  = r_gyro;
    assign o_angle = r_angle;
    assign o_low   = r_low;
    assign o_min   = r_min;
    assign o_max   = r_max;

endmodule

[rtl/gkwd_classify.sv]
module gkwd_classify #(
    parameter int SAMPLE_BITS = gkwd_pkg::SAMPLE_BITS_DEF,
    parameter int WINDOW      = gkwd_pkg::WINDOW_DEF
) (
    input  logic                                 i_fill_done,
    input  logic signed [SAMPLE_BITS-1:0]        i_mid_angle,
    input  logic signed [SAMPLE_BITS-1:0]        i_angle_min,
    input  logic signed [gkwd_pkg::LIM_BITS-1:0] i_angle_lim,
    input  logic signed [SAMPLE_BITS-1:0]        i_mid_gyro,
    input  logic signed [SAMPLE_BITS-1:0]        i_gyro_max,
    input  logic signed [gkwd_pkg::LIM_BITS-1:0] i_gyro_lim,
    input  logic signed [SAMPLE_BITS-1:0]        i_gyro_prev,
    input  logic signed [SAMPLE_BITS-1:0]        i_gyro_next,
    input  logic [$clog2(WINDOW+1)-1:0]          i_low_cnt,
    output logic [gkwd_pkg::CODE_W-1:0]          o_code
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int LIM_W = (SAMPLE_BITS > gkwd_pkg::LIM_BITS) ? SAMPLE_BITS
                                                              : gkwd_pkg::LIM_BITS;

    function automatic logic crosses(logic signed [SAMPLE_BITS-1:0] mid,
                                     logic signed [SAMPLE_BITS-1:0] other);
        logic signed [SAMPLE_BITS:0] mid_x, oth_x, am, ao;
        logic                        opp;
        mid_x = (SAMPLE_BITS+1)'(mid);
        oth_x = (SAMPLE_BITS+1)'(other);
        am    = mid_x[SAMPLE_BITS] ? -mid_x : mid_x;
        ao    = oth_x[SAMPLE_BITS] ? -oth_x : oth_x;
        opp   = (mid[SAMPLE_BITS-1] && !other[SAMPLE_BITS-1] && (other != '0)) ||
                (!mid[SAMPLE_BITS-1] && (mid != '0) && other[SAMPLE_BITS-1]);
        return opp && (am < ao);
    endfunction

    logic angle_hit, gyro_hit, low_hit, cross_hit;

    assign angle_hit = (i_angle_min == i_mid_angle) &&
                       (LIM_W'(i_angle_min) < LIM_W'(i_angle_lim));
    assign gyro_hit  = (i_gyro_max == i_mid_gyro) &&
                       (LIM_W'(i_gyro_max) > LIM_W'(i_gyro_lim));
    assign low_hit   = (i_low_cnt > CNT_W'(WINDOW / 2));
    assign cross_hit = crosses(i_mid_gyro, i_gyro_prev) || crosses(i_mid_gyro, i_gyro_next);

    always_comb begin
        priority if (!i_fill_done) begin
            o_code = gkwd_pkg::CODE_FILL;
        end else if (angle_hit) begin
            o_code = gkwd_pkg::CODE_ANGLE_MIN;
        end else if (gyro_hit) begin
            o_code = gkwd_pkg::CODE_GYRO_PEAK;
        end else if (low_hit) begin
            o_code = gkwd_pkg::CODE_LOW_ACC;
        end else if (cross_hit) begin
            o_code = gkwd_pkg::CODE_ZERO_CROSS;
        end else begin
            o_code = gkwd_pkg::CODE_NORMAL;
        end
    end

endmodule

[rtl/gait_keypoint_window_detector.sv]
// Gait key-point window detector: takes one IMU sample per request and returns one phase
// code for it. A sample is accepted only while the block is idle, and the next one is taken
// only after this one has gone through accept, square, shift, a min/max sweep along the cell
// chain and classify; classify waits while the output register holds a code not yet taken.
// A finished code waits in the output register while the next sample is accepted. Until
// WINDOW samples have arrived the code is 0; afterwards it classifies the middle sample.
`include "gait_keypoint_window_detector_defines.svh"

module gait_keypoint_window_detector #(
    parameter int WINDOW      = gkwd_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = gkwd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [gkwd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gkwd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // acc_x, acc_y, acc_z, gyro_x, angle_x (SAMPLE_BITS each), zero padding
    input  logic [((5*SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // phase_code [2:0], zero padding
    output logic [7:0]                           m_axis_tdata
);

    localparam int B      = SAMPLE_BITS;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SCAN_W = $clog2(WINDOW);
    localparam int MID    = WINDOW / 2;

    gkwd_pkg::t_state r_state, n_state;

    logic [gkwd_pkg::CFG_DATA_W-1:0]      r_acc_sq_limit;
    logic signed [gkwd_pkg::LIM_BITS-1:0] r_angle_lim, r_gyro_lim;

    logic signed [B-1:0]  r_gyro_in, r_angle_in;
    logic [CNT_W-1:0]     r_low_cnt, r_fill;
    logic [SCAN_W-1:0]    r_scan, n_scan;
    logic                 r_out_valid, n_out_valid;
    logic [gkwd_pkg::CODE_W-1:0] r_code, n_code;

    logic                 in_accept, shift, load_mag, low_new;
    logic [gkwd_pkg::CODE_W-1:0] w_code;

    logic signed [B-1:0]  w_gyro  [WINDOW];
    logic signed [B-1:0]  w_angle [WINDOW];
    logic                 w_low   [WINDOW];
    logic signed [B-1:0]  w_min   [WINDOW];
    logic signed [B-1:0]  w_max   [WINDOW];

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign load_mag  = in_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_sq_limit <= gkwd_pkg::ACC_SQ_LIMIT_RST;
            r_angle_lim    <= '0;
            r_gyro_lim     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                gkwd_pkg::REG_ACC_SQ_LIMIT:    r_acc_sq_limit <= i_cfg_data;
                gkwd_pkg::REG_ANGLE_MIN_LIMIT: r_angle_lim <= i_cfg_data[gkwd_pkg::LIM_BITS-1:0];
                gkwd_pkg::REG_GYRO_PEAK_LIMIT: r_gyro_lim  <= i_cfg_data[gkwd_pkg::LIM_BITS-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_gyro_in  <= s_axis_tdata[4*B-1:3*B];
            r_angle_in <= s_axis_tdata[5*B-1:4*B];
        end
    end

    gkwd_mag #(
        .SAMPLE_BITS(B)
    ) u_mag (
        .i_clk   (i_clk),
        .i_load  (load_mag),
        .i_acc_x (s_axis_tdata[B-1:0]),
        .i_acc_y (s_axis_tdata[2*B-1:B]),
        .i_acc_z (s_axis_tdata[3*B-1:2*B]),
        .i_limit (r_acc_sq_limit),
        .o_low   (low_new)
    );

    // Entry 0 is the oldest; samples move down, running extremes move up.
    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        logic signed [B-1:0] nb_gyro, nb_angle, nb_min, nb_max;
        logic                nb_low;
        if (k == WINDOW - 1) begin : g_top
            assign nb_gyro  = r_gyro_in;
            assign nb_angle = r_angle_in;
            assign nb_low   = low_new;
        end else begin : g_mid
            assign nb_gyro  = w_gyro[k+1];
            assign nb_angle = w_angle[k+1];
            assign nb_low   = w_low[k+1];
        end
        if (k == 0) begin : g_first
            assign nb_min = w_angle[0];
            assign nb_max = w_gyro[0];
        end else begin : g_rest
            assign nb_min = w_min[k-1];
            assign nb_max = w_max[k-1];
        end

        gkwd_cell #(
            .SAMPLE_BITS(B)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_gyro  (nb_gyro),
            .i_angle (nb_angle),
            .i_low   (nb_low),
            .i_min   (nb_min),
            .i_max   (nb_max),
            .o_gyro  (w_gyro[k]),
            .o_angle (w_angle[k]),
            .o_low   (w_low[k]),
            .o_min   (w_min[k]),
            .o_max   (w_max[k])
        );
    end

    gkwd_classify #(
        .SAMPLE_BITS(B),
        .WINDOW     (WINDOW)
    ) u_classify (
        .i_fill_done (r_fill == CNT_W'(WINDOW)),
        .i_mid_angle (w_angle[MID]),
        .i_angle_min (w_min[WINDOW-1]),
        .i_angle_lim (r_angle_lim),
        .i_mid_gyro  (w_gyro[MID]),
        .i_gyro_max  (w_max[WINDOW-1]),
        .i_gyro_lim  (r_gyro_lim),
        .i_gyro_prev (w_gyro[MID-1]),
        .i_gyro_next (w_gyro[MID+1]),
        .i_low_cnt   (r_low_cnt),
        .o_code      (w_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gkwd_pkg::ST_IDLE;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
            r_low_cnt   <= '0;
            r_fill      <= '0;
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
            if (shift) begin
                r_low_cnt <= r_low_cnt - CNT_W'(w_low[0]) + CNT_W'(low_new);
                if (r_fill != CNT_W'(WINDOW)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    always_comb begin
        n_state       = r_state;
        n_scan        = r_scan;
        n_code        = r_code;
        n_out_valid   = r_out_valid && !m_axis_tready;
        s_axis_tready = 1'b0;
        shift         = 1'b0;
        unique case (r_state)
            gkwd_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = gkwd_pkg::ST_MUL;
                end
            end
            gkwd_pkg::ST_MUL: begin
                n_state = gkwd_pkg::ST_SHIFT;
            end
            gkwd_pkg::ST_SHIFT: begin
                shift   = 1'b1;
                n_scan  = '0;
                n_state = gkwd_pkg::ST_SCAN;
            end
            gkwd_pkg::ST_SCAN: begin
                // wait until the extremes have crossed the whole chain
                if (r_scan == SCAN_W'(WINDOW - 1)) begin
                    n_state = gkwd_pkg::ST_DONE;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            gkwd_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_code      = w_code;
                    n_out_valid = 1'b1;
                    n_state     = gkwd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gkwd_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(8 - gkwd_pkg::CODE_W){1'b0}}, r_code};

    `GKWD_ASSERT_IMPLY(a_low_cnt_bound, i_clk, i_rst_n, 1'b1, r_low_cnt <= r_fill,
        "low-acceleration count exceeds samples taken")
    `GKWD_ASSERT_IMPLY(a_fill_code, i_clk, i_rst_n,
        (r_state == gkwd_pkg::ST_DONE) && (r_fill != CNT_W'(WINDOW)),
        w_code == gkwd_pkg::CODE_FILL, "nonzero code before window filled")
    `GKWD_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n,
        (r_state == gkwd_pkg::ST_DONE) && (!r_out_valid || m_axis_tready),
        r_out_valid && (r_state == gkwd_pkg::ST_IDLE), "finished result not presented")

endmodule

[tb/gait_keypoint_window_detector_tb.sv]
module gait_keypoint_window_detector_tb;
    import gkwd_pkg::*;

    localparam int WIN          = WINDOW_DEF;
    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int DATA_W       = ((5 * SB + 7) / 8) * 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PRESSURE_AT  = 450;
    localparam int HOLD_CYCLES  = 400;
    localparam int EXP_DEPTH    = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic signed [SB-1:0] S_MIN     = {1'b1, {(SB - 1){1'b0}}};
    localparam logic signed [SB-1:0] S_MAX     = {1'b0, {(SB - 1){1'b1}}};

    // last field in the lowest bits
    typedef struct packed {
        logic signed [SB-1:0] angle_x;
        logic signed [SB-1:0] gyro_x;
        logic signed [SB-1:0] acc_z;
        logic signed [SB-1:0] acc_y;
        logic signed [SB-1:0] acc_x;
    } imu_sample_t;

    typedef struct {
        logic signed [SB-1:0] ax, ay, az, gx, an;
        bit                   typed;
        logic [CODE_W-1:0]    code;
    } directed_row_t;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // acc_x, acc_y, acc_z, gyro_x, angle_x, zero padding
    logic [DATA_W-1:0]     s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // phase_code [2:0], zero padding
    logic [7:0]            m_axis_tdata;

    gait_keypoint_window_detector #(
        .WINDOW      (WIN),
        .SAMPLE_BITS (SB)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Window state and limits of the predictor
    logic signed [SB-1:0]  gyro_win   [WIN] = '{default: '0};
    logic signed [SB-1:0]  angle_win  [WIN] = '{default: '0};
    logic                  lowacc_win [WIN] = '{default: 1'b0};
    int                    lowacc_total     = 0;
    int                    samples_seen     = 0;
    logic [CFG_DATA_W-1:0] lim_acc_sq       = ACC_SQ_LIMIT_RST;
    logic signed [15:0]    lim_angle_min    = '0;
    logic signed [15:0]    lim_gyro_peak    = '0;

    // expected codes in request order
    logic [CODE_W-1:0] exp_codes [EXP_DEPTH];
    int                exp_wr        = 0;
    int                exp_rd        = 0;
    int                mismatches    = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                walk_gyro     = 0;
    int                walk_angle    = 0;

    logic signed [SB-1:0] corner_vals [6] = '{S_MIN, -16'sd1, 16'sd0, 16'sd1, S_MAX, 16'sd2048};

    // ax, ay, az, gx, an, typed, code
    directed_row_t directed_rows [25] = '{
        '{S_MAX, S_MAX, S_MAX, 16'sd0, 16'sd0, 1'b1, CODE_FILL},
        '{S_MIN, S_MIN, S_MIN, 16'sd0, 16'sd0, 1'b1, CODE_FILL},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, CODE_FILL},
        '{16'sd2048, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, CODE_FILL},
        '{16'sd2049, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, CODE_FILL},
        '{16'sd0, -16'sd2048, 16'sd0, 16'sd0, 16'sd0, 1'b1, CODE_FILL},
        '{S_MAX, S_MIN, 16'sd0, 16'sd0, 16'sd0, 1'b1, CODE_FILL},
        '{16'sh5555, 16'shAAAA, 16'sd0, 16'sd300, S_MIN, 1'b1, CODE_FILL},
        '{S_MAX, 16'sd0, 16'sd0, S_MAX, 16'sd0, 1'b1, CODE_FILL},
        '{S_MIN, 16'sd0, 16'sd0, -16'sd5, 16'sd0, 1'b1, CODE_FILL},
        '{S_MAX, 16'sd0, 16'sd0, S_MIN, 16'sd0, 1'b1, CODE_FILL},
        '{S_MAX, 16'sd0, 16'sd0, S_MAX, 16'sd0, 1'b1, CODE_FILL},
        '{16'sd0, 16'sd0, 16'sd0, -16'sd2, 16'sd0, 1'b1, CODE_FILL},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 1'b1, CODE_FILL},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, CODE_FILL},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, CODE_FILL},
        '{16'sd0, 16'sd0, 16'sd0, -16'sd7, 16'sd0, 1'b0, CODE_FILL},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd9, 16'sd0, 1'b0, CODE_FILL},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, CODE_FILL},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 1'b0, CODE_FILL},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, CODE_FILL},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, CODE_FILL},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, CODE_FILL},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, CODE_FILL},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, CODE_FILL}
    };

    function automatic bit crosses_zero(int mid, int other);
        int mid_abs;
        int other_abs;
        mid_abs   = (mid < 0) ? -mid : mid;
        other_abs = (other < 0) ? -other : other;
        return ((mid < 0 && other > 0) || (mid > 0 && other < 0)) && (mid_abs < other_abs);
    endfunction

    // Shift the sample into the window and classify the middle entry
    function automatic logic [CODE_W-1:0] classify_sample(imu_sample_t s);
        longint               mag;
        logic                 is_low;
        logic signed [SB-1:0] angle_lo;
        logic signed [SB-1:0] gyro_hi;
        int                   mid;
        mid = WIN / 2;
        mag = longint'(s.acc_x) * longint'(s.acc_x) + longint'(s.acc_y) * longint'(s.acc_y)
            + longint'(s.acc_z) * longint'(s.acc_z);
        is_low = (mag <= longint'(lim_acc_sq));

        lowacc_total -= int'(lowacc_win[0]);
        for (int i = 0; i + 1 < WIN; i++) begin
            gyro_win[i]   = gyro_win[i + 1];
            angle_win[i]  = angle_win[i + 1];
            lowacc_win[i] = lowacc_win[i + 1];
        end
        gyro_win[WIN - 1]   = s.gyro_x;
        angle_win[WIN - 1]  = s.angle_x;
        lowacc_win[WIN - 1] = is_low;
        lowacc_total += int'(is_low);
        if (samples_seen < WIN) samples_seen++;
        if (samples_seen < WIN) return CODE_FILL;

        angle_lo = angle_win[0];
        gyro_hi  = gyro_win[0];
        for (int i = 1; i < WIN; i++) begin
            if (angle_win[i] < angle_lo) angle_lo = angle_win[i];
            if (gyro_win[i] > gyro_hi) gyro_hi = gyro_win[i];
        end

        if (angle_lo == angle_win[mid] && angle_lo < lim_angle_min) return CODE_ANGLE_MIN;
        if (gyro_hi == gyro_win[mid] && gyro_hi > lim_gyro_peak) return CODE_GYRO_PEAK;
        if (lowacc_total > WIN / 2) return CODE_LOW_ACC;
        if (crosses_zero(gyro_win[mid], gyro_win[mid - 1]) ||
            crosses_zero(gyro_win[mid], gyro_win[mid + 1])) return CODE_ZERO_CROSS;
        return CODE_NORMAL;
    endfunction

    // Mostly a smooth gait-like walk, some raw noise and some corner values
    function automatic imu_sample_t next_imu_sample();
        imu_sample_t s;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            walk_gyro = walk_gyro + int'($urandom_range(1200)) - 600;
            if ($urandom_range(9) == 0) walk_gyro = -walk_gyro;
            if (walk_gyro > 8000) walk_gyro = 8000;
            if (walk_gyro < -8000) walk_gyro = -8000;
            walk_angle = walk_angle + walk_gyro / 8;
            if (walk_angle > 12000) walk_angle = 12000;
            if (walk_angle < -12000) walk_angle = -12000;
            s.acc_x   = SB'(int'($urandom_range(2600)) - 1300);
            s.acc_y   = SB'(int'($urandom_range(2600)) - 1300);
            s.acc_z   = SB'(int'($urandom_range(1600)) + 1000);
            s.gyro_x  = SB'(walk_gyro);
            s.angle_x = SB'(walk_angle);
        end else if (pick < 85) begin
            s.acc_x   = SB'($urandom);
            s.acc_y   = SB'($urandom);
            s.acc_z   = SB'($urandom);
            s.gyro_x  = SB'($urandom);
            s.angle_x = SB'($urandom);
        end else begin
            s.acc_x   = corner_vals[$urandom_range(5)];
            s.acc_y   = corner_vals[$urandom_range(5)];
            s.acc_z   = corner_vals[$urandom_range(5)];
            s.gyro_x  = corner_vals[$urandom_range(5)];
            s.angle_x = corner_vals[$urandom_range(5)];
        end
        return s;
    endfunction

    // Offer one request and record its expected code once it is taken
    task automatic send_sample(imu_sample_t s, bit typed, logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'(s);
        do @(posedge i_clk); while (!s_axis_tready);
        want = classify_sample(s);
        exp_codes[exp_wr % EXP_DEPTH] = typed ? code : want;
        exp_wr++;
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++) send_sample(next_imu_sample(), 1'b0, CODE_FILL);
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait for the block to drain, then load all limits and poke the spare index
    task automatic write_limits(logic [31:0] acc_lim, logic signed [15:0] angle_lim,
                                logic signed [15:0] gyro_lim);
        while (exp_wr != exp_rd) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_ACC_SQ_LIMIT;
        i_cfg_data  <= acc_lim;
        @(posedge i_clk);
        i_cfg_index <= REG_ANGLE_MIN_LIMIT;
        i_cfg_data  <= {16'($urandom), angle_lim};
        @(posedge i_clk);
        i_cfg_index <= REG_GYRO_PEAK_LIMIT;
        i_cfg_data  <= {16'($urandom), gyro_lim};
        @(posedge i_clk);
        i_cfg_index <= REG_SPARE;
        i_cfg_data  <= $urandom;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        lim_acc_sq    = acc_lim;
        lim_angle_min = angle_lim;
        lim_gyro_peak = gyro_lim;
    endtask

    initial begin
        imu_sample_t s;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 54;
        foreach (directed_rows[n]) begin
            s = '{directed_rows[n].an, directed_rows[n].gx, directed_rows[n].az,
                  directed_rows[n].ay, directed_rows[n].ax};
            send_sample(s, directed_rows[n].typed, directed_rows[n].code);
        end
        send_random(200);

        write_limits(32'd3221225472, S_MIN, S_MAX);
        send_idle_pct = 54;
        recv_idle_pct = 28;
        send_random(175);

        // the receiver's long hold-off lands in this stretch
        write_limits(32'd0, 16'sd1500, 16'sd1500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(175);

        write_limits(32'hFFFF_FFFF, S_MAX, S_MIN);
        send_random(100);

        write_limits($urandom_range(32'd1000000, 32'd9000000),
                     16'(int'($urandom_range(8000)) - 4000),
                     16'(int'($urandom_range(8000)) - 4000));
        send_random(125);

        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (WIN + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result side: check each code, drive backpressure
    int hold_left     = 0;
    bit pressure_done = 1'b0;
    int codes_checked = 0;

    always @(posedge i_clk) begin
        logic [CODE_W-1:0] want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                codes_checked++;
                if (exp_wr == exp_rd) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: got %0d", m_axis_tdata);
                end else begin
                    want = exp_codes[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (m_axis_tdata !== {{(8 - CODE_W){1'b0}}, want}) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("phase code mismatch at result %0d: expected %0d, got %0d",
                                     codes_checked, want, m_axis_tdata);
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!pressure_done && codes_checked >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold_left     = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

[files.f]
+incdir+rtl
rtl/gkwd_pkg.sv
rtl/gkwd_mag.sv
rtl/gkwd_cell.sv
rtl/gkwd_classify.sv
rtl/gait_keypoint_window_detector.sv
tb/gait_keypoint_window_detector_tb.sv
